// File: rtl/mexp_pkg.sv
// Shared constants for the modular exponentiation block.
package mexp_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH = 32;
   localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET = FIELD_WIDTH'(2);

endpackage

// File: rtl/mexp_mulmod.sv
// Iterative modular multiplier built around one shared modular add unit.
module mexp_mulmod
   import mexp_pkg::*;
#(
   parameter int WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             mul_start,
   input  logic [WIDTH-1:0] mul_x,
   input  logic [WIDTH-1:0] mul_y,
   input  logic [WIDTH-1:0] mul_m,
   output logic             mul_done,
   output logic [WIDTH-1:0] mul_result
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic             active_ff, active_in;
   logic             add_phase_ff, add_phase_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   logic [WIDTH-1:0] addend;
   logic [WIDTH:0]   sum;
   logic [WIDTH:0]   diff;
   logic [WIDTH-1:0] reduced;

   // The shared unit: (r + addend) mod m, valid for both operands below m.
   always_comb begin
      addend  = add_phase_ff ? mul_x : r_ff;
      sum     = {1'b0, r_ff} + {1'b0, addend};
      diff    = sum - {1'b0, mul_m};
      reduced = (sum >= {1'b0, mul_m}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];
   end

   always_comb begin
      active_in    = active_ff;
      add_phase_in = add_phase_ff;
      done_in      = 1'b0;
      r_in         = r_ff;
      y_in         = y_ff;
      cnt_in       = cnt_ff;
      if (!active_ff) begin
         if (mul_start) begin
            active_in    = 1'b1;
            add_phase_in = 1'b0;
            r_in         = '0;
            y_in         = mul_y;
            cnt_in       = CW'(WIDTH - 1);
         end
      end else begin
         r_in = reduced;
         if (!add_phase_ff && y_ff[WIDTH-1]) begin
            add_phase_in = 1'b1;
         end else begin
            add_phase_in = 1'b0;
            y_in         = {y_ff[WIDTH-2:0], 1'b0};
            if (cnt_ff == '0) begin
               active_in = 1'b0;
               done_in   = 1'b1;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         add_phase_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         active_ff    <= active_in;
         add_phase_ff <= add_phase_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      y_ff   <= y_in;
      cnt_ff <= cnt_in;
   end

   assign mul_done   = done_ff;
   assign mul_result = r_ff;

endmodule

// File: rtl/modexp_square_and_multiply.sv
// Top level: square-and-multiply sequencer for modular exponentiation.
//
// Channel   Direction  Handshake              Payload
// request   in         start && !busy         req_base, req_exponent
// response  out        rsp_valid, one cycle   rsp_power_mod
// csr       in         csr_wr_en              csr_wr_data (modulus)
//
// One transaction takes one reduction of the base and then, per exponent bit,
// one squaring plus one multiplication when the bit is set. Each modular
// multiplication runs through the shared add unit, one doubling per multiplier
// bit plus one addition per set bit, and busy stays high until the result is out.
// A modulus below two returns zero in the cycle after acceptance.
// Reset is synchronous and sets the modulus to two; the receiver cannot stall.
module modexp_square_and_multiply
   import mexp_pkg::*;
#(
   parameter int WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [FIELD_WIDTH-1:0] req_base,
   input  logic [FIELD_WIDTH-1:0] req_exponent,
   output logic                   rsp_valid,
   output logic [FIELD_WIDTH-1:0] rsp_power_mod,
   input  logic                   csr_wr_en,
   input  logic [FIELD_WIDTH-1:0] csr_wr_data
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REDUCE = 2'd1;
   localparam logic [1:0] ST_SQUARE = 2'd2;
   localparam logic [1:0] ST_MULT   = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [FIELD_WIDTH-1:0] modulus_ff, modulus_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                   mul_start_ff, mul_start_in;
   logic [WIDTH-1:0]       mul_x_ff, mul_x_in;
   logic [WIDTH-1:0]       mul_y_ff, mul_y_in;
   logic [WIDTH-1:0]       base_ff, base_in;
   logic [WIDTH-1:0]       exp_ff, exp_in;
   logic [CW-1:0]          bit_ff, bit_in;

   logic [WIDTH-1:0] m_use;
   logic             mul_done;
   logic [WIDTH-1:0] mul_result;

   assign m_use = WIDTH'(modulus_ff);

   mexp_mulmod #(
      .WIDTH (WIDTH)
   ) u_mulmod (
      .clock      (clock),
      .reset      (reset),
      .mul_start  (mul_start_ff),
      .mul_x      (mul_x_ff),
      .mul_y      (mul_y_ff),
      .mul_m      (m_use),
      .mul_done   (mul_done),
      .mul_result (mul_result)
   );

   always_comb begin
      state_in     = state_ff;
      modulus_in   = csr_wr_en ? csr_wr_data : modulus_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mul_start_in = 1'b0;
      mul_x_in     = mul_x_ff;
      mul_y_in     = mul_y_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      bit_in       = bit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (m_use < WIDTH'(2)) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
               end else begin
                  exp_in       = WIDTH'(req_exponent);
                  mul_x_in     = WIDTH'(1);
                  mul_y_in     = WIDTH'(req_base);
                  mul_start_in = 1'b1;
                  state_in     = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               base_in      = mul_result;
               mul_x_in     = WIDTH'(1);
               mul_y_in     = WIDTH'(1);
               mul_start_in = 1'b1;
               bit_in       = CW'(WIDTH - 1);
               state_in     = ST_SQUARE;
            end
         end
         ST_SQUARE, ST_MULT: begin
            if (mul_done) begin
               if (state_ff == ST_SQUARE && exp_ff[WIDTH-1]) begin
                  mul_x_in     = mul_result;
                  mul_y_in     = base_ff;
                  mul_start_in = 1'b1;
                  state_in     = ST_MULT;
               end else if (bit_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = FIELD_WIDTH'(mul_result);
                  state_in     = ST_IDLE;
               end else begin
                  bit_in       = bit_ff - CW'(1);
                  exp_in       = {exp_ff[WIDTH-2:0], 1'b0};
                  mul_x_in     = mul_result;
                  mul_y_in     = mul_result;
                  mul_start_in = 1'b1;
                  state_in     = ST_SQUARE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_start_ff <= mul_start_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      mul_x_ff    <= mul_x_in;
      mul_y_ff    <= mul_y_in;
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      bit_ff      <= bit_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_power_mod = rsp_data_ff;

endmodule
